FILE: hdl/dzls_pkg.sv
// ----------------------------------------------------------------------------
// dzls_pkg: shared types and constants of the distance zone LED selector
// Colour codes, configuration indexes, reset values and the structs that
// move between the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dzls_pkg;

  localparam int unsigned DistW    = 15;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  // wide enough for sample +/- band and near + band, signed
  localparam int unsigned CmpW     = 18;

  typedef enum logic [1:0] {
    COLOUR_OFF    = 2'd0,
    COLOUR_GREEN  = 2'd1,
    COLOUR_YELLOW = 2'd2,
    COLOUR_RED    = 2'd3
  } colour_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAR     = 3'd0,
    CFG_MID     = 3'd1,
    CFG_NEAR    = 3'd2,
    CFG_HYST    = 3'd3,
    CFG_TIMEOUT = 3'd4
  } cfg_idx_e;

  localparam logic [DistW-1:0]    FarReset     = 15'd2000;
  localparam logic [DistW-1:0]    MidReset     = 15'd1000;
  localparam logic [DistW-1:0]    NearReset    = 15'd500;
  localparam logic [DistW-1:0]    HystReset    = 15'd50;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd60;

  typedef struct packed {
    logic [DistW-1:0]    far_distance;
    logic [DistW-1:0]    mid_distance;
    logic [DistW-1:0]    near_distance;
    logic [DistW-1:0]    hysteresis_distance;
    logic [TimeoutW-1:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_mm;
    logic               sample_valid;
    logic [TimeW-1:0]   now_seconds;
  } item_t;

  typedef struct packed {
    colour_e            colour_held;
    logic               enable_flag;
    logic [SampleW-1:0] previous_sample;
    logic [TimeW-1:0]   last_change_time;
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/dzls_sample_if.sv
// ----------------------------------------------------------------------------
// dzls_sample_if: sample channel
// One distance sample with its valid flag and the current time per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzls_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_mm;
  logic               sample_valid;
  logic [31:0]        now_seconds;

  modport source (output valid, sample_mm, sample_valid, now_seconds, input ready);
  modport sink   (input valid, sample_mm, sample_valid, now_seconds, output ready);
endinterface

`default_nettype wire

FILE: hdl/dzls_result_if.sv
// ----------------------------------------------------------------------------
// dzls_result_if: result channel
// Ring colour and enable flag, one word per sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzls_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] led_colour;
  logic       leds_enabled;

  modport source (output valid, led_colour, leds_enabled, input ready);
  modport sink   (input valid, led_colour, leds_enabled, output ready);
endinterface

`default_nettype wire

FILE: hdl/dzls_cfg_if.sv
// ----------------------------------------------------------------------------
// dzls_cfg_if: configuration write channel
// Register index and write data per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/distance_zone_led_selector_unit.sv
// Path: input register, then result register loaded with the state update;
//   a sample moves on once the result register is empty or drains.
// Throughput: one sample per cycle while the result side takes words; the step
//   logic is a handful of 18-bit compares and one 32-bit subtract in between.
// Reset: rst_ni clears control, colour (off), enable, stored sample, change
//   time, and loads the zone and timeout registers with their defaults.
// ----------------------------------------------------------------------------
// distance_zone_led_selector_unit: top level
// Picks a ring colour from distance zones and tracks activity to switch the
// LEDs off after an idle period. Configuration writes are taken at any time
// and are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_zone_led_selector_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  dzls_sample_if.sink   in_i,
  dzls_result_if.source out_o,
  dzls_cfg_if.sink      cfg_i
);

  // configuration registers
  dzls_pkg::cfg_t   cfg_q;

  // input stage
  logic             in_valid_q;
  dzls_pkg::item_t  in_q;

  // result stage
  logic             out_valid_q;
  dzls_pkg::colour_e out_colour_q;
  logic             out_enabled_q;

  // block state
  dzls_pkg::state_t state_q;
  dzls_pkg::state_t state_d;

  logic             advance;
  logic             in_take;

  // Advance the held sample when the result register is empty or drains now.
  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  // Take a new word whenever the input register is free or moves on.
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  // Configuration write; drop indexes beyond the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.far_distance        <= dzls_pkg::FarReset;
      cfg_q.mid_distance        <= dzls_pkg::MidReset;
      cfg_q.near_distance       <= dzls_pkg::NearReset;
      cfg_q.hysteresis_distance <= dzls_pkg::HystReset;
      cfg_q.idle_timeout        <= dzls_pkg::TimeoutReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dzls_pkg::CFG_FAR: begin
          cfg_q.far_distance <= cfg_i.data[dzls_pkg::DistW-1:0];
        end
        dzls_pkg::CFG_MID: begin
          cfg_q.mid_distance <= cfg_i.data[dzls_pkg::DistW-1:0];
        end
        dzls_pkg::CFG_NEAR: begin
          cfg_q.near_distance <= cfg_i.data[dzls_pkg::DistW-1:0];
        end
        dzls_pkg::CFG_HYST: begin
          cfg_q.hysteresis_distance <= cfg_i.data[dzls_pkg::DistW-1:0];
        end
        dzls_pkg::CFG_TIMEOUT: begin
          cfg_q.idle_timeout <= cfg_i.data[dzls_pkg::TimeoutW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the word until it advances into the step logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.sample_mm    <= in_i.sample_mm;
      in_q.sample_valid <= in_i.sample_valid;
      in_q.now_seconds  <= in_i.now_seconds;
    end
  end

  dzls_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d)
  );

  // State moves only when a sample advances, so each sample sees the state
  // left by the one before it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.colour_held      <= dzls_pkg::COLOUR_OFF;
      state_q.enable_flag      <= 1'b0;
      state_q.previous_sample  <= '0;
      state_q.last_change_time <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on advance, clear once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_colour_q  <= state_d.colour_held;
      out_enabled_q <= state_d.enable_flag;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.led_colour   = out_colour_q;
  assign out_o.leds_enabled = out_enabled_q;

  // Input stalls only when a word waits behind a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // State holds between samples.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an advancing sample");

  // A disabled block shows no colour on the next result.
  a_off_when_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !state_q.enable_flag) |=> (out_colour_q == dzls_pkg::COLOUR_OFF))
    else $error("colour shown while disabled");

  // The enable flag in the result matches the stored flag.
  a_enable_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (out_enabled_q == state_q.enable_flag)))
    else $error("result enable differs from stored flag");

endmodule

`default_nettype wire

FILE: hdl/dzls_step.sv
// ----------------------------------------------------------------------------
// dzls_step: next-state logic for one sample
// Zone colour choice followed by the activity and idle timeout check.
// ----------------------------------------------------------------------------
`default_nettype none

module dzls_step (
  input  dzls_pkg::cfg_t   cfg_i,
  input  dzls_pkg::state_t state_i,
  input  dzls_pkg::item_t  item_i,
  output dzls_pkg::state_t state_o
);

  localparam int unsigned CmpW = dzls_pkg::CmpW;
  localparam int unsigned ExtD = CmpW - dzls_pkg::DistW;
  localparam int unsigned ExtS = CmpW - dzls_pkg::SampleW;

  logic signed [CmpW-1:0] d;
  logic signed [CmpW-1:0] prev;
  logic signed [CmpW-1:0] far_v;
  logic signed [CmpW-1:0] mid_v;
  logic signed [CmpW-1:0] near_v;
  logic signed [CmpW-1:0] hyst_v;
  logic signed [CmpW-1:0] near_hyst;
  logic signed [CmpW-1:0] prev_lo;
  logic signed [CmpW-1:0] prev_hi;
  logic                   activity;
  logic [dzls_pkg::TimeW-1:0] elapsed;
  logic                   timed_out;

  assign d      = {{ExtS{item_i.sample_mm[dzls_pkg::SampleW-1]}}, item_i.sample_mm};
  assign prev   = {{ExtS{state_i.previous_sample[dzls_pkg::SampleW-1]}},
                   state_i.previous_sample};
  assign far_v  = {{ExtD{1'b0}}, cfg_i.far_distance};
  assign mid_v  = {{ExtD{1'b0}}, cfg_i.mid_distance};
  assign near_v = {{ExtD{1'b0}}, cfg_i.near_distance};
  assign hyst_v = {{ExtD{1'b0}}, cfg_i.hysteresis_distance};

  assign near_hyst = near_v + hyst_v;
  assign prev_lo   = prev - hyst_v;
  assign prev_hi   = prev + hyst_v;

  assign activity  = item_i.sample_valid && ((d < prev_lo) || (d > prev_hi));
  assign elapsed   = item_i.now_seconds - state_i.last_change_time;
  assign timed_out = elapsed >= {{(dzls_pkg::TimeW - dzls_pkg::TimeoutW){1'b0}},
                                 cfg_i.idle_timeout};

  always_comb begin
    state_o = state_i;

    // colour uses the enable flag from before this sample
    if (item_i.sample_valid && state_i.enable_flag) begin
      priority if ((d > far_v) || (d < 0)) begin
        state_o.colour_held = dzls_pkg::COLOUR_GREEN;
      end else if ((d < mid_v) && (d > near_hyst)) begin
        state_o.colour_held = dzls_pkg::COLOUR_YELLOW;
      end else if ((d < near_v) && (d > 0)) begin
        state_o.colour_held = dzls_pkg::COLOUR_RED;
      end else begin
        state_o.colour_held = state_i.colour_held;
      end
    end else begin
      state_o.colour_held = dzls_pkg::COLOUR_OFF;
    end

    priority if (activity) begin
      state_o.previous_sample  = item_i.sample_mm;
      state_o.last_change_time = item_i.now_seconds;
      state_o.enable_flag      = 1'b1;
    end else if (timed_out) begin
      state_o.last_change_time = item_i.now_seconds;
      state_o.enable_flag      = 1'b0;
    end else begin
      state_o.enable_flag      = state_i.enable_flag;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_distance_zone_led_selector_unit.sv
// ----------------------------------------------------------------------------
// tb_distance_zone_led_selector_unit: self-checking bench of the zone selector
// Streams distance samples through the block under several zone and timeout
// set-ups, mirrors the colour and activity logic in a local model and checks
// every result word against it, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_distance_zone_led_selector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet spell tolerated; the deliberate receiver hold-off is far
  // shorter, so only a hung block trips this.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallPercent  = 14;
  localparam int unsigned WalkPerPhase  = 195;
  localparam int unsigned SetupCount    = 8;
  // Index past the register list; the block must drop such a write.
  localparam logic [dzls_pkg::CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  typedef struct {
    logic signed [15:0] sample_mm;
    logic               sample_valid;
    logic [31:0]        now_seconds;
  } sample_word_t;

  typedef struct {
    dzls_pkg::colour_e colour;
    logic              enabled;
  } ring_word_t;

  logic clk_i;
  logic rst_ni;

  dzls_sample_if sample_ch ();
  dzls_result_if ring_ch ();
  dzls_cfg_if    cfg_ch ();

  distance_zone_led_selector_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .out_o  (ring_ch),
    .cfg_i  (cfg_ch)
  );

  // Mirror of the zone registers, loaded with the reset defaults.
  logic [dzls_pkg::DistW-1:0]    far_mm         = dzls_pkg::FarReset;
  logic [dzls_pkg::DistW-1:0]    mid_mm         = dzls_pkg::MidReset;
  logic [dzls_pkg::DistW-1:0]    near_mm        = dzls_pkg::NearReset;
  logic [dzls_pkg::DistW-1:0]    hyst_mm        = dzls_pkg::HystReset;
  logic [dzls_pkg::TimeoutW-1:0] idle_timeout_s = dzls_pkg::TimeoutReset;

  // Mirror of the selector state.
  dzls_pkg::colour_e  held_colour    = dzls_pkg::COLOUR_OFF;
  logic               ring_enabled   = 1'b0;
  logic signed [15:0] prev_sample_mm = '0;
  logic [31:0]        last_change_s  = '0;

  sample_word_t samples_to_send[$];
  ring_word_t   ring_forecast[$];

  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned rings_seen       = 0;
  int unsigned reg_writes       = 0;
  int unsigned failures         = 0;
  int unsigned quiet_cycles     = 0;

  bit sample_taken = 1'b0;
  bit steady_phase = 1'b0;
  bit hold_request = 1'b0;

  // Random walk that the generator follows between phases.
  int          walk_mm  = 0;
  logic [31:0] walk_now = '0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model: colour choice on the old enable flag, then the activity check
  // --------------------------------------------------------------------------
  function automatic void step_zone_model(input sample_word_t w);
    ring_word_t  due;
    int          d;
    int          prev;
    int          band;
    logic [31:0] elapsed;
    d    = $signed(w.sample_mm);
    prev = $signed(prev_sample_mm);
    band = int'(hyst_mm);
    // Colour first; a sample sitting in a zone gap keeps the held colour.
    if (w.sample_valid && ring_enabled) begin
      if (d > int'(far_mm) || d < 0) begin
        held_colour = dzls_pkg::COLOUR_GREEN;
      end else if (d < int'(mid_mm) && d > int'(near_mm) + band) begin
        held_colour = dzls_pkg::COLOUR_YELLOW;
      end else if (d < int'(near_mm) && d > 0) begin
        held_colour = dzls_pkg::COLOUR_RED;
      end
    end else begin
      held_colour = dzls_pkg::COLOUR_OFF;
    end
    // Activity outside the band re-arms; otherwise time out on a wrapped delta.
    elapsed = w.now_seconds - last_change_s;
    if (w.sample_valid && (d < prev - band || d > prev + band)) begin
      prev_sample_mm = w.sample_mm;
      last_change_s  = w.now_seconds;
      ring_enabled   = 1'b1;
    end else if (elapsed >= {16'h0000, idle_timeout_s}) begin
      last_change_s = w.now_seconds;
      ring_enabled  = 1'b0;
    end
    due.colour  = held_colour;
    due.enabled = ring_enabled;
    ring_forecast.push_back(due);
  endfunction

  function automatic void load_zone_reg(input logic [dzls_pkg::CfgIdxW-1:0] idx,
                                        input logic [dzls_pkg::CfgDataW-1:0] value);
    case (idx)
      dzls_pkg::CFG_FAR:     far_mm         = value[dzls_pkg::DistW-1:0];
      dzls_pkg::CFG_MID:     mid_mm         = value[dzls_pkg::DistW-1:0];
      dzls_pkg::CFG_NEAR:    near_mm        = value[dzls_pkg::DistW-1:0];
      dzls_pkg::CFG_HYST:    hyst_mm        = value[dzls_pkg::DistW-1:0];
      dzls_pkg::CFG_TIMEOUT: idle_timeout_s = value[dzls_pkg::TimeoutW-1:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_sample(input int mm, input logic ok,
                                      input logic [31:0] now);
    sample_word_t w;
    w.sample_mm    = mm[15:0];
    w.sample_valid = ok;
    w.now_seconds  = now;
    samples_to_send.push_back(w);
    samples_queued++;
  endfunction

  // Mostly small moves around the band edges and the zone bounds, with time
  // creeping forward and now and then stepping over the timeout, jumping or
  // running backwards.
  function automatic sample_word_t next_walk_word();
    sample_word_t w;
    int v;
    int band;
    band = int'(hyst_mm);
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 65535));
      1, 2: begin
        case ($urandom_range(0, 4))
          0:       v = int'(far_mm);
          1:       v = int'(mid_mm);
          2:       v = int'(near_mm);
          3:       v = int'(near_mm) + band;
          default: v = 0;
        endcase
        v = v + int'($urandom_range(0, 4)) - 2;
      end
      3, 4: begin
        v = band + int'($urandom_range(0, 2)) - 1;
        v = ($urandom_range(0, 1) == 1) ? walk_mm + v : walk_mm - v;
      end
      5, 6: v = walk_mm + int'($urandom_range(0, 2 * band + 4)) - band - 2;
      default: v = walk_mm + int'($urandom_range(0, 600)) - 300;
    endcase
    walk_mm = $signed(v[15:0]);
    case ($urandom_range(0, 19))
      0:       walk_now = $urandom;
      1:       walk_now = walk_now - $urandom_range(1, 100);
      2, 3:    walk_now = walk_now + {16'h0000, idle_timeout_s} + $urandom_range(0, 2) - 1;
      default: walk_now = walk_now + $urandom_range(0, idle_timeout_s / 8 + 2);
    endcase
    w.sample_mm    = v[15:0];
    w.sample_valid = ($urandom_range(0, 99) >= 12);
    w.now_seconds  = walk_now;
    return w;
  endfunction

  function automatic void queue_walk(input int unsigned count);
    sample_word_t w;
    for (int unsigned k = 0; k < count; k++) begin
      w = next_walk_word();
      samples_to_send.push_back(w);
      samples_queued++;
    end
  endfunction

  // Call from the falling edge; leaves the write channel offering the word.
  task automatic write_zone_reg(input logic [dzls_pkg::CfgIdxW-1:0] idx,
                                input logic [dzls_pkg::CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    load_zone_reg(idx, value);
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic apply_zone_setup(input int unsigned far_v, input int unsigned mid_v,
                                  input int unsigned near_v, input int unsigned hyst_v,
                                  input int unsigned timeout_v);
    write_zone_reg(dzls_pkg::CFG_FAR, 16'(far_v));
    write_zone_reg(dzls_pkg::CFG_MID, 16'(mid_v));
    write_zone_reg(dzls_pkg::CFG_NEAR, 16'(near_v));
    write_zone_reg(dzls_pkg::CFG_HYST, 16'(hyst_v));
    write_zone_reg(dzls_pkg::CFG_TIMEOUT, 16'(timeout_v));
  endtask

  // Hold the sender until every queued sample has gone in and come back.
  task automatic wait_for_drain();
    while (samples_accepted != samples_queued || ring_forecast.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: hold a word until taken, then advance or idle at random
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sample_word_t offer;
    if (rst_ni && (!sample_ch.valid || sample_taken)) begin
      sample_taken = 1'b0;
      if (samples_to_send.size() > 0 &&
          (steady_phase || $urandom_range(0, 99) >= StallPercent)) begin
        offer = samples_to_send.pop_front();
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_mm    <= offer.sample_mm;
        sample_ch.sample_valid <= offer.sample_valid;
        sample_ch.now_seconds  <= offer.now_seconds;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off on request so the
  // block backs up and stalls its sample input
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ring_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ring_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldOffCycles;
      ring_ch.ready <= 1'b0;
    end else begin
      ring_ch.ready <= steady_phase || ($urandom_range(0, 99) >= StallPercent);
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: check the result word first, then forecast the sample taken
  // on the same edge, so a same-edge result can never match its own sample
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ring_word_t   due;
    sample_word_t got;
    if (rst_ni && ring_ch.valid && ring_ch.ready) begin
      rings_seen++;
      if (ring_forecast.size() == 0) begin
        $error("result word with no sample outstanding: led_colour %0d leds_enabled %0b",
               ring_ch.led_colour, ring_ch.leds_enabled);
        failures++;
      end else begin
        due = ring_forecast.pop_front();
        if (ring_ch.led_colour !== due.colour) begin
          $error("led_colour: expected %0d, got %0d", due.colour, ring_ch.led_colour);
          failures++;
        end
        if (ring_ch.leds_enabled !== due.enabled) begin
          $error("leds_enabled: expected %0b, got %0b", due.enabled, ring_ch.leds_enabled);
          failures++;
        end
      end
    end
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      got.sample_mm    = sample_ch.sample_mm;
      got.sample_valid = sample_ch.sample_valid;
      got.now_seconds  = sample_ch.now_seconds;
      step_zone_model(got);
      samples_accepted++;
      sample_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count edges with no handshake on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_ch.valid && sample_ch.ready) || (ring_ch.valid && ring_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, ring_forecast.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sample_ch.valid        = 1'b0;
    sample_ch.sample_mm    = '0;
    sample_ch.sample_valid = 1'b0;
    sample_ch.now_seconds  = '0;
    ring_ch.ready          = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = dzls_pkg::CFG_FAR;
    cfg_ch.data            = '0;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pass on the reset set-up. The enable flag starts clear, so the
    // first sample must move outside the band before any colour shows.
    push_sample(-1, 1'b0, 32'hFFFF_FFFF);     // not a number, time at its top
    push_sample(1000, 1'b1, 32'h0000_0000);   // first activity
    push_sample(32767, 1'b1, 1);              // beyond far
    push_sample(-32768, 1'b1, 2);             // negative reads as green
    push_sample(0, 1'b1, 3);                  // zero sits in no zone
    push_sample(700, 1'b1, 4);                // yellow
    push_sample(300, 1'b1, 5);                // red
    push_sample(520, 1'b1, 6);                // gap between near and near + band
    push_sample(540, 1'b1, 7);                // inside the band: no activity
    push_sample(540, 1'b0, 8);                // invalid drops the colour
    push_sample(540, 1'b1, 9);                // gap now holds off
    push_sample(560, 1'b1, 70);               // idle long enough: disable
    push_sample(560, 1'b1, 71);
    push_sample(2000, 1'b1, 72);              // exactly far
    push_sample(2001, 1'b1, 73);
    push_sample(1000, 1'b1, 74);              // exactly mid
    push_sample(500, 1'b1, 75);               // exactly near
    push_sample(550, 1'b1, 76);               // exactly near + band, band edge
    push_sample(551, 1'b1, 77);
    push_sample(1000, 1'b1, 32'hFFFF_FFF0);
    push_sample(1010, 1'b1, 32'h0000_0020);   // time wraps, still short
    push_sample(1010, 1'b1, 32'h0000_002C);   // wrapped delta hits the timeout
    push_sample(1010, 1'b1, 32'h0000_0005);   // time runs backwards
    push_sample(-32768, 1'b1, 32'h8000_0000);
    walk_now = 32'h8000_0000;
    walk_mm  = -32768;
    queue_walk(WalkPerPhase - 30);
    wait_for_drain();

    for (int unsigned phase = 1; phase < SetupCount; phase++) begin
      case (phase)
        1: apply_zone_setup(0, 0, 0, 0, 0);
        // Top bit set on the distance registers; only 15 bits are kept.
        2: apply_zone_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_zone_setup(3000, 1000, 2500, 20, 30);   // near above mid
        4: apply_zone_setup($urandom_range(1200, 2000), $urandom_range(600, 1200),
                            $urandom_range(100, 600), $urandom_range(1, 40),
                            $urandom_range(5, 50));
        5: apply_zone_setup(2000, 1000, 500, 0, 1);
        6: apply_zone_setup($urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 65535));
        default: apply_zone_setup(dzls_pkg::FarReset, dzls_pkg::MidReset,
                                  dzls_pkg::NearReset, dzls_pkg::HystReset,
                                  dzls_pkg::TimeoutReset);
      endcase
      if (phase == 2) begin
        write_zone_reg(CfgUnusedIdx, 16'($urandom_range(0, 65535)));
      end
      cfg_ch.valid <= 1'b0;
      @(posedge clk_i);
      steady_phase = (phase == 4);
      hold_request = (phase == 3);
      queue_walk(WalkPerPhase);
      wait_for_drain();
    end

    // Drain, then give a late or stray result word time to show up.
    repeat (8) @(posedge clk_i);
    if (ring_forecast.size() != 0) begin
      $error("%0d results never arrived", ring_forecast.size());
      failures++;
    end

    $display("Covered %0d samples under %0d zone set-ups (%0d register writes),",
             samples_accepted, SetupCount, reg_writes);
    $display("with a long receiver hold-off and a full-rate stretch; %0d results checked.",
             rings_seen);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
